@@ src/ecpa_pkg.sv @@
// Shared constants for the elliptic-curve point unit.
// No dependencies.
package ecpa_pkg;
   localparam int FIELD_BITS_DEF  = 31;
   localparam int SCALAR_BITS_DEF = 31;
   localparam int ADDR_BITS       = 3;
   localparam logic [ADDR_BITS-1:0] ADDR_MODULUS = 3'd0;
   localparam logic [ADDR_BITS-1:0] ADDR_CURVE_A = 3'd4;
   localparam logic ACTION_ADD = 1'b0;
   localparam logic ACTION_MUL = 1'b1;
   // arithmetic unit op codes
   localparam logic [2:0] OP_RED = 3'd0;
   localparam logic [2:0] OP_ADD = 3'd1;
   localparam logic [2:0] OP_SUB = 3'd2;
   localparam logic [2:0] OP_MUL = 3'd3;
   localparam logic [2:0] OP_INV = 3'd4;
endpackage

@@ src/ec_point_add_and_scalar_mult.sv @@
// Top level of the elliptic-curve point unit: CSRs, sequencer, result register.
// Depends on ecpa_pkg and ecpa_alu.
//
// Usage: load modulus (address 0) and curve_a (address 4) over the csr_ port
// while idle. A request transaction (req_) carries action, two affine points
// and a scalar; action 0 adds p1 and p2, action 1 forms scalar*p1 by
// left-to-right double-and-add. (0,0) is the point at infinity.
// One response transaction (rsp_) follows each request.
// All arithmetic runs through one bit-serial modular unit: a multiply or a
// reduction works through the operand one bit per step, an add or sub
// computes and then corrects by the modulus once, and an inverse runs shift
// or subtract steps until the remainder is zero. An add request starts with
// five input reductions and a multiply request with three; a point add
// costs 3 to 5 multiplies, six adds or subs and one inverse. A scalar
// multiply costs up to 2*(SCALAR_BITS-1) point operations. One request is
// processed at a time; req_ready is high only while the sequencer is idle.
// A stalled receiver holds rsp_valid
// and the payload; the next request is accepted and computed, then waits in
// the output state until the result is taken. Reset clears the sequencer,
// drops rsp_valid and restores modulus 2^31-1 and curve_a 0.
module ec_point_add_and_scalar_mult
   import ecpa_pkg::*;
#(
   parameter int FIELD_BITS  = FIELD_BITS_DEF,
   parameter int SCALAR_BITS = SCALAR_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_action,
   input  logic [FIELD_BITS-1:0]  req_p1x,
   input  logic [FIELD_BITS-1:0]  req_p1y,
   input  logic [FIELD_BITS-1:0]  req_p2x,
   input  logic [FIELD_BITS-1:0]  req_p2y,
   input  logic [SCALAR_BITS-1:0] req_scalar,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [FIELD_BITS-1:0]  rsp_rx,
   output logic [FIELD_BITS-1:0]  rsp_ry,
   output logic                   rsp_at_infinity,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [ADDR_BITS-1:0]   csr_paddr,
   input  logic [31:0]            csr_pwdata,
   output logic [31:0]            csr_prdata,
   output logic                   csr_pready
);
   localparam int W = FIELD_BITS;
   localparam int KW = $clog2(SCALAR_BITS + 1);

   // sequencer states
   localparam logic [4:0] S_IDLE = 5'd0,  S_RA = 5'd1,  S_RX1 = 5'd2, S_RY1 = 5'd3,
                          S_RX2 = 5'd4,  S_RY2 = 5'd5,  S_PSEL = 5'd6, S_BIT = 5'd7,
                          S_PADD = 5'd8, S_D1 = 5'd9,   S_D2 = 5'd10,  S_D3 = 5'd11,
                          S_D4 = 5'd12,  S_C1 = 5'd13,  S_C2 = 5'd14,  S_INV = 5'd15,
                          S_L = 5'd16,   S_X1 = 5'd17,  S_X2 = 5'd18,  S_X3 = 5'd19,
                          S_Y1 = 5'd20,  S_Y2 = 5'd21,  S_Y3 = 5'd22,  S_PEND = 5'd23,
                          S_NEXT = 5'd24, S_OUT = 5'd25;

   logic [W-1:0] mod_ff, ca_ff;
   logic [4:0]   st_ff, st_in;
   logic         act_ff;
   logic [W-1:0] a_ff, x1_ff, y1_ff, bx_ff, by_ff, qx_ff, qy_ff, rx_ff, ry_ff;
   logic [W-1:0] num_ff, den_ff, lam_ff, x3_ff, t_ff;
   logic [SCALAR_BITS-1:0] k_ff, req_k_ff;
   logic [KW-1:0] kc_ff;
   logic         sdone_ff;   // add phase of current scalar bit done
   logic [W-1:0] ix2_ff, iy2_ff;
   logic         go;
   logic [2:0]   aop;
   logic [W-1:0] aa, ab, ares;
   logic         adone, afail;
   logic         ov_ff;
   logic [W-1:0] o_rx_ff, o_ry_ff;
   logic         o_inf_ff;

   ecpa_alu #(.W(W)) u_alu (
      .clock(clock), .reset(reset), .start(go), .op(aop), .a_in(aa), .b_in(ab),
      .m_in(mod_ff), .done(adone), .result(ares), .fail(afail)
   );

   // CSR port
   assign csr_pready = 1'b1;
   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr)
         ADDR_MODULUS: csr_prdata = 32'(mod_ff);
         ADDR_CURVE_A: csr_prdata = 32'(ca_ff);
         default: csr_prdata = '0;
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         mod_ff <= W'(64'h7FFF_FFFF);
         ca_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr == ADDR_MODULUS) mod_ff <= W'(csr_pwdata);
         if (csr_paddr == ADDR_CURVE_A) ca_ff <= W'(csr_pwdata);
      end
   end

   assign req_ready = (st_ff == S_IDLE);
   assign rsp_valid = ov_ff;
   assign rsp_rx = o_rx_ff;
   assign rsp_ry = o_ry_ff;
   assign rsp_at_infinity = o_inf_ff;

   // launch one ALU op when entering an arithmetic state
   logic wait_ff;
   always_comb begin
      aop = OP_RED; aa = '0; ab = '0;
      unique case (st_ff)
         S_RA:  begin aop = OP_RED; aa = ca_ff; end
         S_RX1: begin aop = OP_RED; aa = x1_ff; end
         S_RY1: begin aop = OP_RED; aa = y1_ff; end
         S_RX2: begin aop = OP_RED; aa = bx_ff; end
         S_RY2: begin aop = OP_RED; aa = by_ff; end
         S_D1:  begin aop = OP_MUL; aa = qx_ff; ab = qx_ff; end
         S_D2:  begin aop = OP_MUL; aa = t_ff; ab = W'(3) >= mod_ff ? W'(3) - mod_ff : W'(3); end
         S_D3:  begin aop = OP_ADD; aa = t_ff; ab = a_ff; end
         S_D4:  begin aop = OP_ADD; aa = qy_ff; ab = qy_ff; end
         S_C1:  begin aop = OP_SUB; aa = iy2_ff; ab = qy_ff; end
         S_C2:  begin aop = OP_SUB; aa = ix2_ff; ab = qx_ff; end
         S_INV: begin aop = OP_INV; aa = den_ff; end
         S_L:   begin aop = OP_MUL; aa = num_ff; ab = t_ff; end
         S_X1:  begin aop = OP_MUL; aa = lam_ff; ab = lam_ff; end
         S_X2:  begin aop = OP_SUB; aa = t_ff; ab = qx_ff; end
         S_X3:  begin aop = OP_SUB; aa = t_ff; ab = ix2_ff; end
         S_Y1:  begin aop = OP_SUB; aa = qx_ff; ab = x3_ff; end
         S_Y2:  begin aop = OP_MUL; aa = lam_ff; ab = t_ff; end
         S_Y3:  begin aop = OP_SUB; aa = t_ff; ab = qy_ff; end
         default: ;
      endcase
   end
   always_comb begin
      go = 1'b0;
      unique case (st_ff)
         S_RA, S_RX1, S_RY1, S_RX2, S_RY2, S_D1, S_D2, S_D3, S_D4, S_C1, S_C2,
         S_INV, S_L, S_X1, S_X2, S_X3, S_Y1, S_Y2, S_Y3: go = !wait_ff;
         default: go = 1'b0;
      endcase
   end

   // sequencer
   logic step;
   assign step = wait_ff && adone;
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; wait_ff <= 1'b0; ov_ff <= 1'b0;
      end else begin
         // the output state reloads the register itself
         if (ov_ff && rsp_ready && st_ff != S_OUT) ov_ff <= 1'b0;
         if (go) wait_ff <= 1'b1;
         if (step) wait_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (req_valid) begin
               act_ff <= req_action; x1_ff <= req_p1x; y1_ff <= req_p1y;
               bx_ff <= req_p2x; by_ff <= req_p2y; req_k_ff <= req_scalar;
               st_ff <= (mod_ff < W'(2)) ? S_PEND : S_RA;
               rx_ff <= '0; ry_ff <= '0; kc_ff <= '0;
            end
            S_RA:  if (step) begin a_ff <= ares; st_ff <= S_RX1; end
            S_RX1: if (step) begin x1_ff <= ares; st_ff <= S_RY1; end
            S_RY1: if (step) begin
               y1_ff <= ares;
               st_ff <= (act_ff == ACTION_ADD) ? S_RX2 : S_BIT;
               rx_ff <= x1_ff; ry_ff <= ares;
               k_ff <= req_k_ff; kc_ff <= KW'(SCALAR_BITS); sdone_ff <= 1'b0;
            end
            S_RX2: if (step) begin bx_ff <= ares; st_ff <= S_RY2; end
            S_RY2: if (step) begin
               by_ff <= ares;
               qx_ff <= x1_ff; qy_ff <= y1_ff; ix2_ff <= bx_ff; iy2_ff <= ares;
               sdone_ff <= 1'b1; kc_ff <= '0;
               st_ff <= S_PADD;
            end
            // find leading one, then double-and-add per bit
            S_BIT: begin
               if (kc_ff == '0) st_ff <= S_PEND;
               else if (k_ff[SCALAR_BITS-1]) begin
                  // leading one found: proceed with remaining bits
                  k_ff <= k_ff << 1; kc_ff <= kc_ff - 1'b1; st_ff <= S_NEXT;
               end else begin
                  k_ff <= k_ff << 1; kc_ff <= kc_ff - 1'b1;
               end
            end
            S_NEXT: begin
               if (kc_ff == '0) st_ff <= S_PEND;
               else begin
                  qx_ff <= rx_ff; qy_ff <= ry_ff; ix2_ff <= rx_ff; iy2_ff <= ry_ff;
                  sdone_ff <= 1'b0; st_ff <= S_PADD;
               end
            end
            S_PSEL: begin
               // after doubling: add base if bit set, else move to next bit
               if (k_ff[SCALAR_BITS-1]) begin
                  qx_ff <= rx_ff; qy_ff <= ry_ff; ix2_ff <= x1_ff; iy2_ff <= y1_ff;
                  sdone_ff <= 1'b1; st_ff <= S_PADD;
               end else begin
                  k_ff <= k_ff << 1; kc_ff <= kc_ff - 1'b1; st_ff <= S_NEXT;
               end
            end
            // point add of (qx,qy)+(ix2,iy2)
            S_PADD: begin
               if (qx_ff == '0 && qy_ff == '0) begin
                  rx_ff <= ix2_ff; ry_ff <= iy2_ff; st_ff <= S_PEND;
               end else if (ix2_ff == '0 && iy2_ff == '0) begin
                  rx_ff <= qx_ff; ry_ff <= qy_ff; st_ff <= S_PEND;
               end else if (qx_ff == ix2_ff) begin
                  if (qy_ff != iy2_ff || qy_ff == '0) begin
                     rx_ff <= '0; ry_ff <= '0; st_ff <= S_PEND;
                  end else st_ff <= S_D1;
               end else st_ff <= S_C1;
            end
            S_D1: if (step) begin t_ff <= ares; st_ff <= S_D2; end
            S_D2: if (step) begin t_ff <= ares; st_ff <= S_D3; end
            S_D3: if (step) begin num_ff <= ares; st_ff <= S_D4; end
            S_D4: if (step) begin den_ff <= ares; st_ff <= S_INV; end
            S_C1: if (step) begin num_ff <= ares; st_ff <= S_C2; end
            S_C2: if (step) begin den_ff <= ares; st_ff <= S_INV; end
            S_INV: if (step) begin
               if (afail || den_ff == '0) begin
                  rx_ff <= '0; ry_ff <= '0; st_ff <= S_PEND;
               end else begin t_ff <= ares; st_ff <= S_L; end
            end
            S_L:  if (step) begin lam_ff <= ares; st_ff <= S_X1; end
            S_X1: if (step) begin t_ff <= ares; st_ff <= S_X2; end
            S_X2: if (step) begin t_ff <= ares; st_ff <= S_X3; end
            S_X3: if (step) begin x3_ff <= ares; st_ff <= S_Y1; end
            S_Y1: if (step) begin t_ff <= ares; st_ff <= S_Y2; end
            S_Y2: if (step) begin t_ff <= ares; st_ff <= S_Y3; end
            S_Y3: if (step) begin rx_ff <= x3_ff; ry_ff <= ares; st_ff <= S_PEND; end
            // end of one point op: continue scalar loop or finish
            S_PEND: begin
               if (act_ff == ACTION_MUL && kc_ff != '0 && st_ff == S_PEND) begin
                  if (!sdone_ff) st_ff <= S_PSEL;
                  else begin
                     k_ff <= k_ff << 1; kc_ff <= kc_ff - 1'b1; st_ff <= S_NEXT;
                  end
               end else if (act_ff == ACTION_MUL && !sdone_ff && kc_ff != '0) begin
                  st_ff <= S_PSEL;
               end else st_ff <= S_OUT;
            end
            S_OUT: if (!ov_ff || rsp_ready) begin
               ov_ff <= 1'b1;
               o_rx_ff <= rx_ff; o_ry_ff <= ry_ff;
               o_inf_ff <= (rx_ff == '0) && (ry_ff == '0);
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // a response is only produced from the output state
   assert property (@(posedge clock) disable iff (reset)
      $rose(ov_ff) |-> $past(st_ff) == S_OUT)
      else $error("response without finishing");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_infinity |-> rsp_rx == '0 && rsp_ry == '0)
      else $error("infinity with nonzero coordinates");
   assert property (@(posedge clock) disable iff (reset)
      go |-> !wait_ff)
      else $error("alu started twice");
endmodule

@@ src/ecpa_alu.sv @@
// Bit-serial modular arithmetic unit: reduce, add, sub, multiply, inverse.
// Depends on ecpa_pkg.
module ecpa_alu
   import ecpa_pkg::*;
#(
   parameter int W = FIELD_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [2:0]   op,
   input  logic [W-1:0] a_in,
   input  logic [W-1:0] b_in,
   input  logic [W-1:0] m_in,
   output logic         done,
   output logic [W-1:0] result,
   output logic         fail
);
   localparam int CW = $clog2(2*W+2);

   logic [2:0]   op_ff;
   logic         busy_ff, busy_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W:0]   acc_ff, acc_in;
   logic [W:0]   x_ff, x_in;
   logic [W-1:0] y_ff, y_in;
   logic [W:0]   u_ff, u_in, v_ff, v_in;
   logic [W:0]   r_ff, r_in, s_ff, s_in;
   logic [W:0]   td_ff, td_in;
   logic         fail_ff, fail_in, done_ff, done_in;
   logic [W:0]   m_ext, t0, t1, t2, t3;

   assign m_ext = {1'b0, m_in};
   assign result = acc_ff[W-1:0];
   assign done = done_ff;
   assign fail = fail_ff;

   always_comb begin
      busy_in = busy_ff; cnt_in = cnt_ff; acc_in = acc_ff; x_in = x_ff; y_in = y_ff;
      u_in = u_ff; v_in = v_ff; r_in = r_ff; s_in = s_ff; fail_in = fail_ff;
      td_in = td_ff;
      done_in = 1'b0;
      t0 = '0; t1 = '0; t2 = '0; t3 = '0;
      if (start && !busy_ff) begin
         busy_in = 1'b1; fail_in = 1'b0; cnt_in = '0;
         unique case (op)
            OP_RED: begin acc_in = '0; x_in = {1'b0, a_in}; end
            OP_ADD: acc_in = {1'b0, a_in} + {1'b0, b_in};
            OP_SUB: acc_in = {1'b0, a_in} - {1'b0, b_in};
            OP_MUL: begin acc_in = '0; x_in = {1'b0, a_in}; y_in = b_in; end
            // r0 = m, r1 = a, t0 = 0, t1 = 1; divisor copy starts at r1
            OP_INV: begin
               u_in = m_ext; v_in = {1'b0, a_in};
               r_in = '0; s_in = {{W{1'b0}}, 1'b1};
               x_in = {1'b0, a_in}; td_in = {{W{1'b0}}, 1'b1};
               fail_in = (a_in == '0);
            end
            default: ;
         endcase
      end else if (busy_ff) begin
         unique case (op_ff)
            // shift in one bit of the operand per cycle, MSB first
            OP_RED: begin
               t0 = {acc_ff[W-1:0], x_ff[W-1]};
               acc_in = (t0 >= m_ext) ? t0 - m_ext : t0;
               x_in = {x_ff[W-1:0], 1'b0};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CW'(W-1)) begin busy_in = 1'b0; done_in = 1'b1; end
            end
            OP_ADD: begin
               if (acc_ff >= m_ext) acc_in = acc_ff - m_ext;
               busy_in = 1'b0; done_in = 1'b1;
            end
            OP_SUB: begin
               if (acc_ff[W]) acc_in = acc_ff + m_ext;
               busy_in = 1'b0; done_in = 1'b1;
            end
            // LSB-first shift-and-add
            OP_MUL: begin
               t0 = acc_ff + x_ff;
               if (y_ff[0]) acc_in = (t0 >= m_ext) ? t0 - m_ext : t0;
               t1 = {x_ff[W-1:0], 1'b0};
               x_in = (t1 >= m_ext) ? t1 - m_ext : t1;
               y_in = y_ff >> 1;
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CW'(W-1)) begin busy_in = 1'b0; done_in = 1'b1; end
            end
            // shift-and-subtract extended Euclid, works for any modulus:
            // keeps r0 = t0*a and r1 = t1*a (mod m); each cycle either doubles
            // the divisor copy (x, td) or subtracts it from (r0, t0), swapping
            // the pairs once r0 drops below r1
            OP_INV: begin
               t0 = {x_ff[W-1:0], 1'b0};
               t1 = u_ff - x_ff;
               t2 = (r_ff >= td_ff) ? r_ff - td_ff : r_ff + m_ext - td_ff;
               t3 = {td_ff[W-1:0], 1'b0};
               if (fail_ff) begin
                  busy_in = 1'b0; done_in = 1'b1;
               end else if (v_ff == '0) begin
                  if (u_ff == {{W{1'b0}}, 1'b1}) acc_in = r_ff;
                  else fail_in = 1'b1;
                  busy_in = 1'b0; done_in = 1'b1;
               end else if (t0 <= u_ff) begin
                  x_in = t0;
                  td_in = (t3 >= m_ext) ? t3 - m_ext : t3;
               end else if (t1 < v_ff) begin
                  u_in = v_ff; v_in = t1; r_in = s_ff; s_in = t2;
                  x_in = t1; td_in = t2;
               end else begin
                  u_in = t1; r_in = t2; x_in = v_ff; td_in = s_ff;
               end
            end
            default: begin busy_in = 1'b0; done_in = 1'b1; end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; fail_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; fail_ff <= fail_in;
      end
      if (start && !busy_ff) op_ff <= op;
      cnt_ff <= cnt_in; acc_ff <= acc_in; x_ff <= x_in; y_ff <= y_in;
      u_ff <= u_in; v_ff <= v_in; r_ff <= r_in; s_ff <= s_in; td_ff <= td_in;
   end

   // done is a single pulse after a busy phase
   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("alu done while busy");
   assert property (@(posedge clock) disable iff (reset) done_ff |-> $past(busy_ff))
      else $error("alu done without work");
   assert property (@(posedge clock) disable iff (reset) done_ff |=> !done_ff)
      else $error("alu done longer than one cycle");
endmodule

@@ tb/ec_point_add_and_scalar_mult_test.sv @@
// Self-checking testbench for ec_point_add_and_scalar_mult: point add and scalar multiply.
// Depends on ecpa_pkg and the RTL; expected points come from an in-bench field predictor.
module ec_point_add_and_scalar_mult_test;
   import ecpa_pkg::*;

   localparam int FW = FIELD_BITS_DEF;
   localparam int SW = SCALAR_BITS_DEF;
   localparam longint unsigned PRIME_MAX = 64'd2147483647;

   typedef struct packed {
      logic [FW-1:0] rx;
      logic [FW-1:0] ry;
      logic          inf;
   } ec_point_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic          req_action = ACTION_ADD;
   logic [FW-1:0] req_p1x = '0;
   logic [FW-1:0] req_p1y = '0;
   logic [FW-1:0] req_p2x = '0;
   logic [FW-1:0] req_p2y = '0;
   logic [SW-1:0] req_scalar = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [FW-1:0] rsp_rx;
   logic [FW-1:0] rsp_ry;
   logic          rsp_at_infinity;
   logic          csr_psel = 1'b0;
   logic          csr_penable = 1'b0;
   logic          csr_pwrite = 1'b0;
   logic [ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0]   csr_pwdata = '0;
   logic [31:0]   csr_prdata;
   logic          csr_pready;

   // shadow of the field registers
   longint unsigned field_p = PRIME_MAX;
   longint unsigned coef_a = 0;

   ec_point_type expected_points[$];
   int errors = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;

   ec_point_add_and_scalar_mult dut (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #(8 * 20_000_000);
      $display("ec_point_add_and_scalar_mult verification failed");
      $finish;
   end

   // ---------------- field predictor ----------------
   function automatic longint unsigned fmul(longint unsigned x, longint unsigned y,
                                            longint unsigned m);
      return (x * y) % m;
   endfunction

   function automatic longint unsigned fsub(longint unsigned x, longint unsigned y,
                                            longint unsigned m);
      return (x >= y) ? x - y : x + m - y;
   endfunction

   // extended Euclid; ok low when v has no inverse
   function automatic bit finv(longint unsigned v, longint unsigned m,
                               output longint unsigned inv);
      longint r0, r1, t0, t1, q, tmp;
      r0 = m; r1 = v; t0 = 0; t1 = 1;
      while (r1 != 0) begin
         q = r0 / r1;
         tmp = r0 - q * r1; r0 = r1; r1 = tmp;
         tmp = t0 - q * t1; t0 = t1; t1 = tmp;
      end
      if (t0 < 0) t0 += m;
      inv = t0;
      return r0 == 1;
   endfunction

   // affine add, inputs already reduced; (0,0) is infinity
   function automatic void point_sum(longint unsigned m, longint unsigned a,
                                     longint unsigned x1, longint unsigned y1,
                                     longint unsigned x2, longint unsigned y2,
                                     output longint unsigned xr, output longint unsigned yr);
      longint unsigned num, den, inv, lam, x3;
      if (x1 == 0 && y1 == 0) begin xr = x2; yr = y2; return; end
      if (x2 == 0 && y2 == 0) begin xr = x1; yr = y1; return; end
      xr = 0; yr = 0;
      if (x1 == x2) begin
         if (y1 != y2 || y1 == 0) return;
         num = (fmul(3 % m, fmul(x1, x1, m), m) + a) % m;
         den = (2 * y1) % m;
      end else begin
         num = fsub(y2, y1, m);
         den = fsub(x2, x1, m);
      end
      if (den == 0 || !finv(den, m, inv)) return;
      lam = fmul(num, inv, m);
      x3 = fsub(fsub(fmul(lam, lam, m), x1, m), x2, m);
      yr = fsub(fmul(lam, fsub(x1, x3, m), m), y1, m);
      xr = x3;
   endfunction

   function automatic ec_point_type predict_point(bit action, longint unsigned p1x,
      longint unsigned p1y, longint unsigned p2x, longint unsigned p2y, longint unsigned k);
      ec_point_type res;
      longint unsigned m, a, x1, y1, rx, ry;
      int top;
      m = field_p; rx = 0; ry = 0; top = -1;
      if (m >= 2) begin
         a = coef_a % m; x1 = p1x % m; y1 = p1y % m;
         if (action == ACTION_ADD) begin
            point_sum(m, a, x1, y1, p2x % m, p2y % m, rx, ry);
         end else begin
            rx = x1; ry = y1;
            for (int i = SW - 1; i >= 0; i--)
               if (top < 0 && k[i]) top = i;
            for (int i = top - 1; i >= 0; i--) begin
               point_sum(m, a, rx, ry, rx, ry, rx, ry);
               if (k[i]) point_sum(m, a, rx, ry, x1, y1, rx, ry);
            end
         end
      end
      res.rx = rx[FW-1:0];
      res.ry = ry[FW-1:0];
      res.inf = (rx == 0 && ry == 0);
      return res;
   endfunction

   // ---------------- result side ----------------
   // ready pattern, with an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // compare each response transaction against the oldest expected point
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected response rx=%0d ry=%0d inf=%0b", $time,
                     rsp_rx, rsp_ry, rsp_at_infinity);
            errors++;
         end else begin
            ec_point_type e;
            e = expected_points.pop_front();
            if (rsp_rx !== e.rx) begin
               $display("%0t: rx expected %0d actual %0d", $time, e.rx, rsp_rx);
               errors++;
            end
            if (rsp_ry !== e.ry) begin
               $display("%0t: ry expected %0d actual %0d", $time, e.ry, rsp_ry);
               errors++;
            end
            if (rsp_at_infinity !== e.inf) begin
               $display("%0t: at_infinity expected %0b actual %0b", $time, e.inf,
                        rsp_at_infinity);
               errors++;
            end
         end
      end
   end

   // ---------------- request side ----------------
   task automatic send_request(bit action, longint unsigned p1x, longint unsigned p1y,
                               longint unsigned p2x, longint unsigned p2y,
                               longint unsigned k);
      bit done;
      done = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_action <= action;
      req_p1x    <= p1x[FW-1:0];
      req_p1y    <= p1y[FW-1:0];
      req_p2x    <= p2x[FW-1:0];
      req_p2y    <= p2y[FW-1:0];
      req_scalar <= k[SW-1:0];
      while (!done) begin
         @(posedge clock);
         done = req_ready;
      end
      expected_points.push_back(predict_point(action, p1x, p1y, p2x, p2y, k));
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_points.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [ADDR_BITS-1:0] addr, longint unsigned value);
      @(negedge clock);
      csr_psel <= 1'b1; csr_penable <= 1'b0; csr_pwrite <= 1'b1;
      csr_paddr <= addr; csr_pwdata <= value[31:0];
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == ADDR_MODULUS) field_p = value[FW-1:0];
      else coef_a = value[FW-1:0];
   endtask

   task automatic set_curve(longint unsigned p, longint unsigned a);
      write_csr(ADDR_MODULUS, p);
      write_csr(ADDR_CURVE_A, a);
   endtask

   function automatic longint unsigned rand_coord();
      if ($urandom_range(9) == 0) return $urandom_range(2147483646);
      return $urandom % field_p;
   endfunction

   // ---------------- tests ----------------
   task automatic test_add_corners;
      longint unsigned x, y;
      set_curve(PRIME_MAX, 2147483646);
      x = 123456789; y = 987654321;
      send_request(ACTION_ADD, 0, 0, 0, 0, 0);                 // infinity + infinity
      send_request(ACTION_ADD, 0, 0, x, y, 0);                 // infinity + P
      send_request(ACTION_ADD, x, y, 0, 0, 0);                 // P + infinity
      send_request(ACTION_ADD, x, y, x, PRIME_MAX - y, 0);     // P + (-P)
      send_request(ACTION_ADD, x, 0, x, 0, 0);                 // doubling with y zero
      send_request(ACTION_ADD, x, y, x, 5, 0);                 // same x, other y
      send_request(ACTION_ADD, x, y, x, y, 0);                 // tangent
      send_request(ACTION_ADD, 2147483646, 2147483646, 1, 2, 0);
      send_request(ACTION_ADD, 2147483646, 1, 1, 2147483646, 0);
      drain();
      // coordinates far above the modulus get reduced
      set_curve(97, 0);
      send_request(ACTION_ADD, 2147483646, 1431655765, 715827882, 97, 0);
      send_request(ACTION_ADD, 97 + 3, 194 + 6, 3, 6, 0);
      drain();
   endtask

   task automatic test_mul_corners;
      set_curve(PRIME_MAX, 0);
      send_request(ACTION_MUL, 55555, 77777, 0, 0, 0);
      send_request(ACTION_MUL, 55555, 77777, 0, 0, 1);
      send_request(ACTION_MUL, 55555, 77777, 0, 0, 2);
      send_request(ACTION_MUL, 55555, 77777, 0, 0, 3);
      send_request(ACTION_MUL, 0, 0, 0, 0, 12345);             // multiple of infinity
      send_request(ACTION_MUL, 42, 0, 0, 0, 2);                // y zero doubles to infinity
      send_request(ACTION_MUL, 1431655765, 715827882, 0, 0, 31'h7fffffff);
      drain();
      set_curve(3, 1);
      send_request(ACTION_MUL, 2147483646, 2147483645, 0, 0, 31'h2aaaaaaa);
      drain();
   endtask

   // receiver stops for a long stretch while requests keep coming
   task automatic test_backpressure;
      set_curve(13, 2);
      hold_off_cycles = 3000;
      repeat (6) send_request(ACTION_ADD, rand_coord(), rand_coord(),
                              rand_coord(), rand_coord(), 0);
      drain();
   endtask

   task automatic test_random(int s_idle, int r_idle, longint unsigned p,
                              longint unsigned a, int count);
      int mode;
      longint unsigned x, y, k;
      set_curve(p, a);
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      repeat (count) begin
         mode = $urandom_range(99);
         x = rand_coord();
         y = rand_coord();
         if (mode < 35) begin
            send_request(ACTION_ADD, x, y, rand_coord(), rand_coord(), 0);
         end else if (mode < 50) begin
            send_request(ACTION_ADD, x, y, x, y, 0);
         end else if (mode < 60) begin
            send_request(ACTION_ADD, x, y, x % field_p, fsub(0, y % field_p, field_p), 0);
         end else if (mode < 70) begin
            send_request(ACTION_ADD, 0, 0, x, y, 0);
         end else begin
            k = $urandom & ((32'd1 << $urandom_range(1, 10)) - 1);
            if ($urandom_range(15) == 0) k = $urandom & 32'h7fffffff;
            send_request(ACTION_MUL, x, y, $urandom, $urandom, k);
         end
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_add_corners();
      test_mul_corners();
      test_backpressure();
      test_random(11, 66, 97, 2, 15);
      test_random(11, 66, PRIME_MAX, 2147483646, 15);
      test_random(66, 11, 7, 3, 15);
      test_random(66, 11, 65521, 0, 10);
      test_random(0, 0, 3, 1, 10);
      test_random(0, 0, 1000003, 5, 10);
      repeat (100) @(posedge clock);
      if (errors == 0)
         $display("ec_point_add_and_scalar_mult verification clean");
      else
         $display("ec_point_add_and_scalar_mult verification failed");
      $finish;
   end
endmodule
